@@ sv/srtc_pkg.sv @@
// Package with constants and pipeline payload types for the rate calculator.
package srtc_pkg;

    localparam logic [15:0] RATE_MIN        = 16'd4000;
    localparam logic [15:0] RATE_MAX        = 16'd44100;
    localparam logic [15:0] RATE_STEREO_MAX = 16'd22050;
    localparam logic [15:0] HS_THRESHOLD    = 16'd22050;
    localparam logic [27:0] HS_NUMERATOR    = 28'd256000000;
    localparam logic [27:0] LS_NUMERATOR    = 28'd1000000;
    localparam logic [16:0] HS_FULL_SCALE   = 17'd65536;
    localparam logic [20:0] RATE_NUMERATOR2 = 21'd2000000;

    localparam int Q1_BITS = 14;
    localparam int Q2_BITS = 16;

    typedef struct packed {
        logic [15:0]        divisor;
        logic [15:0]        rem;
        logic [Q1_BITS-1:0] qbits;
        logic               hs;
        logic               clamped;
        logic               stereo;
    } div1_t;

    typedef struct packed {
        logic [8:0]         divisor;
        logic [8:0]         rem;
        logic [Q2_BITS-1:0] qbits;
        logic [7:0]         tc;
        logic               hs;
        logic               clamped;
        logic               stereo;
    } div2_t;

endpackage

@@ sv/srtc_front.sv @@
// Input stage that clamps the requested rate and sets up the first division.
module srtc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stereo,
    input  logic                 valid_in,
    input  logic [19:0]          rate_in,
    output logic                 ready_out,
    output logic                 valid_out,
    output srtc_pkg::div1_t      data_out,
    input  logic                 ready_in
);
    import srtc_pkg::*;

    logic        valid_reg;
    div1_t       data_reg;
    div1_t       data_next;
    logic [15:0] r_clamp;
    logic [15:0] r_conv;
    logic        clamp_flag;
    logic        hs;
    logic [27:0] dividend;

    always_comb
    begin
        clamp_flag = 1'b0;
        if (rate_in < {4'd0, RATE_MIN})
        begin
            r_clamp    = RATE_MIN;
            clamp_flag = 1'b1;
        end
        else if (rate_in > {4'd0, RATE_MAX})
        begin
            r_clamp    = RATE_MAX;
            clamp_flag = 1'b1;
        end
        else
        begin
            r_clamp = rate_in[15:0];
        end
        if (stereo && (r_clamp > RATE_STEREO_MAX))
        begin
            r_clamp    = RATE_STEREO_MAX;
            clamp_flag = 1'b1;
        end
        r_conv = stereo ? {r_clamp[14:0], 1'b0} : r_clamp;
        hs = (r_conv > HS_THRESHOLD);
        dividend = (hs ? HS_NUMERATOR : LS_NUMERATOR) + {13'd0, r_conv[15:1]};
        data_next.divisor = r_conv;
        data_next.rem     = {2'd0, dividend[27:Q1_BITS]};
        data_next.qbits   = dividend[Q1_BITS-1:0];
        data_next.hs      = hs;
        data_next.clamped = clamp_flag;
        data_next.stereo  = stereo;
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ sv/srtc_div1_cell.sv @@
// One restoring division step of the first quotient chain.
module srtc_div1_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  srtc_pkg::div1_t      data_in,
    output logic                 ready_out,
    output logic                 valid_out,
    output srtc_pkg::div1_t      data_out,
    input  logic                 ready_in
);
    import srtc_pkg::*;

    logic        valid_reg;
    div1_t       data_reg;
    div1_t       data_next;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        qbit;

    always_comb
    begin
        trial = {data_in.rem, data_in.qbits[Q1_BITS-1]};
        diff  = trial - {1'b0, data_in.divisor};
        qbit  = (trial >= {1'b0, data_in.divisor});
        data_next       = data_in;
        data_next.rem   = qbit ? diff[15:0] : trial[15:0];
        data_next.qbits = {data_in.qbits[Q1_BITS-2:0], qbit};
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ sv/srtc_mid.sv @@
// Stage that forms the time constant and sets up the achieved-rate division.
module srtc_mid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  srtc_pkg::div1_t      data_in,
    output logic                 ready_out,
    output logic                 valid_out,
    output srtc_pkg::div2_t      data_out,
    input  logic                 ready_in
);
    import srtc_pkg::*;

    logic        valid_reg;
    div2_t       data_reg;
    div2_t       data_next;
    logic [16:0] hs_span;
    logic [7:0]  tc;
    logic [7:0]  dd;
    logic [8:0]  dd_full;
    logic [20:0] dividend;

    always_comb
    begin
        hs_span = HS_FULL_SCALE - {3'd0, data_in.qbits};
        tc      = data_in.hs ? hs_span[15:8] : (8'd0 - data_in.qbits[7:0]);
        dd_full = 9'd256 - {1'b0, tc};
        dd      = dd_full[7:0];
        // The low-speed path rounds with a truncated half divisor.
        dividend = RATE_NUMERATOR2 + {13'd0, dd} - {20'd0, (!data_in.hs && dd[0])};
        data_next.divisor = {dd, 1'b0};
        data_next.rem     = {4'd0, dividend[20:Q2_BITS]};
        data_next.qbits   = dividend[Q2_BITS-1:0];
        data_next.tc      = tc;
        data_next.hs      = data_in.hs;
        data_next.clamped = data_in.clamped;
        data_next.stereo  = data_in.stereo;
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ sv/srtc_div2_cell.sv @@
// One restoring division step of the achieved-rate quotient chain.
module srtc_div2_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  srtc_pkg::div2_t      data_in,
    output logic                 ready_out,
    output logic                 valid_out,
    output srtc_pkg::div2_t      data_out,
    input  logic                 ready_in
);
    import srtc_pkg::*;

    logic       valid_reg;
    div2_t      data_reg;
    div2_t      data_next;
    logic [9:0] trial;
    logic [9:0] diff;
    logic       qbit;

    always_comb
    begin
        trial = {data_in.rem, data_in.qbits[Q2_BITS-1]};
        diff  = trial - {1'b0, data_in.divisor};
        qbit  = (trial >= {1'b0, data_in.divisor});
        data_next       = data_in;
        data_next.rem   = qbit ? diff[8:0] : trial[8:0];
        data_next.qbits = {data_in.qbits[Q2_BITS-2:0], qbit};
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ sv/sample_rate_time_constant.sv @@
// Top level of the sample-rate to time-constant calculator.
//
// A request enters on in_valid/in_ready with requested_rate and leaves on
// out_valid/out_ready with time_constant, high_speed, actual_rate and
// rate_clamped. Each transfer on the input gives exactly one output transfer.
// The stereo_mode register is written through cfg_we/cfg_wdata and is sampled
// with each request as it enters.
// The pipeline has one clamp stage, 14 division cells for the time constant,
// one setup stage and 16 division cells for the achieved rate. Throughput is
// one request per cycle while out_ready is high; each cell handles one item.
// Each cell has its own valid bit and ready, so bubbles close up while the
// receiver stalls and the chain keeps taking requests until all 32 cells hold
// one. Reset empties every cell and clears stereo_mode to mono.
module sample_rate_time_constant (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [19:0] requested_rate,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  time_constant,
    output logic        high_speed,
    output logic [15:0] actual_rate,
    output logic        rate_clamped
);
    import srtc_pkg::*;

    logic  stereo_mode_reg;

    logic  v1    [0:Q1_BITS];
    logic  rdy1  [0:Q1_BITS];
    div1_t d1    [0:Q1_BITS];
    logic  v2    [0:Q2_BITS];
    logic  rdy2  [0:Q2_BITS];
    div2_t d2    [0:Q2_BITS];
    logic  mid_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            stereo_mode_reg <= cfg_wdata;
        end
    end

    srtc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .stereo    (stereo_mode_reg),
        .valid_in  (in_valid),
        .rate_in   (requested_rate),
        .ready_out (in_ready),
        .valid_out (v1[0]),
        .data_out  (d1[0]),
        .ready_in  (rdy1[0])
    );

    for (genvar i = 0; i < Q1_BITS; i++)
    begin : g_div1
        srtc_div1_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (v1[i]),
            .data_in   (d1[i]),
            .ready_out (rdy1[i]),
            .valid_out (v1[i+1]),
            .data_out  (d1[i+1]),
            .ready_in  (rdy1[i+1])
        );
    end

    assign rdy1[Q1_BITS] = mid_ready;

    srtc_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v1[Q1_BITS]),
        .data_in   (d1[Q1_BITS]),
        .ready_out (mid_ready),
        .valid_out (v2[0]),
        .data_out  (d2[0]),
        .ready_in  (rdy2[0])
    );

    for (genvar j = 0; j < Q2_BITS; j++)
    begin : g_div2
        srtc_div2_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (v2[j]),
            .data_in   (d2[j]),
            .ready_out (rdy2[j]),
            .valid_out (v2[j+1]),
            .data_out  (d2[j+1]),
            .ready_in  (rdy2[j+1])
        );
    end

    assign rdy2[Q2_BITS] = out_ready;

    assign out_valid     = v2[Q2_BITS];
    assign time_constant = d2[Q2_BITS].tc;
    assign high_speed    = d2[Q2_BITS].hs;
    assign rate_clamped  = d2[Q2_BITS].clamped;
    assign actual_rate   = d2[Q2_BITS].stereo ? {1'b0, d2[Q2_BITS].qbits[Q2_BITS-1:1]}
                                              : d2[Q2_BITS].qbits;

endmodule
